// ===== hw/rtl/hsf_pkg.sv =====
// Package for the Hamming-window STFT framer.
// Holds sizes, the window and twiddle tables, and the structs between modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package hsf_pkg;

    localparam int WINDOW_LEN = 32;
    localparam int IDX_W      = $clog2(WINDOW_LEN);
    localparam int FILL_W     = IDX_W + 1;
    localparam int NUM_BINS   = WINDOW_LEN / 2 + 1;
    localparam int STRIDE_MIN = (WINDOW_LEN + 1) / 2;
    localparam int STRIDE_MAX = 4096;
    localparam int ACC_W      = 38;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint HAM_A_Q30 = 64'sd579820585;
    localparam longint HAM_B_Q30 = 64'sd493921239;

    typedef logic signed [15:0] coef_tab_t [WINDOW_LEN];

    // Write of one windowed sample into the transform buffer.
    typedef struct packed {
        logic                    en;
        logic [IDX_W-1:0]        addr;
        logic signed [15:0]      data;
    } hsf_tb_wr_t;

    // One multiply-accumulate step of the transform.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] tw;
        logic             last;
    } hsf_mac_cmd_t;

    // Unsigned long division by shift and subtract; returns the quotient,
    // or the remainder when get_rem is set. Used at elaboration only.
    function automatic longint unsigned long_div(longint unsigned a, longint unsigned b,
                                                 logic get_rem);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], a[i]};
            if (rem >= b)
            begin
                rem    = rem - b;
                quo[i] = 1'b1;
            end
        end
        return get_rem ? rem : quo;
    endfunction

    // Cosine of 2*pi*num/den in Q2.30 by a Taylor series; used at elaboration.
    function automatic longint cos_q30(longint unsigned num, longint unsigned den);
        longint unsigned p;
        longint unsigned t;
        longint unsigned q;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned tc;
        longint unsigned ts;
        longint c;
        longint s;
        longint unsigned k;
        p  = long_div(num, den, 1'b1);
        t  = 4 * p;
        q  = long_div(t, den, 1'b0);
        r  = t - q * den;
        x  = long_div(HALF_PI_Q30 * r + (den >> 1), den, 1'b0);
        x2 = (x * x) >> 30;
        tc = 64'd1 << 30;
        ts = x;
        c  = longint'(tc);
        s  = longint'(ts);
        for (k = 1; k <= 12; k++) begin
            tc = long_div((tc * x2) >> 30, (2 * k - 1) * (2 * k), 1'b0);
            ts = long_div((ts * x2) >> 30, (2 * k) * (2 * k + 1), 1'b0);
            if (k[0]) begin
                c = c - longint'(tc);
                s = s - longint'(ts);
            end else begin
                c = c + longint'(tc);
                s = s + longint'(ts);
            end
        end
        case (q)
            0:       return c;
            1:       return -s;
            2:       return -c;
            default: return s;
        endcase
    endfunction

    // Round Q2.30 to Q1.15, half away from zero, with saturation.
    function automatic logic signed [15:0] to_q15(longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : longint'(v);
        m = (m + 64'd16384) >> 15;
        if (v < 0) begin
            if (m > 64'd32768) return -16'sd32768;
            return 16'(-longint'(m));
        end
        if (m > 64'd32767) return 16'sd32767;
        return 16'(m);
    endfunction

    function automatic coef_tab_t build_win();
        coef_tab_t tab;
        longint c;
        longint w;
        for (int n = 0; n < WINDOW_LEN; n++) begin
            c = cos_q30(longint'(n), longint'(WINDOW_LEN - 1));
            w = HAM_A_Q30 - (HAM_B_Q30 * c) / 64'sd1073741824;
            tab[n] = to_q15(w);
        end
        return tab;
    endfunction

    function automatic coef_tab_t build_cos();
        coef_tab_t tab;
        for (int n = 0; n < WINDOW_LEN; n++) begin
            tab[n] = to_q15(cos_q30(longint'(n), longint'(WINDOW_LEN)));
        end
        return tab;
    endfunction

    function automatic coef_tab_t build_sin();
        coef_tab_t tab;
        for (int n = 0; n < WINDOW_LEN; n++) begin
            tab[n] = to_q15(cos_q30(longint'(4 * n + 3 * WINDOW_LEN),
                                    longint'(4 * WINDOW_LEN)));
        end
        return tab;
    endfunction

    localparam coef_tab_t WIN_TAB = build_win();
    localparam coef_tab_t COS_TAB = build_cos();
    localparam coef_tab_t SIN_TAB = build_sin();

endpackage
`default_nettype wire

// ===== hw/rtl/hamming_stft_frames.sv =====
// Streaming STFT with a 32-point symmetric Hamming window, 17 bins per frame.
// A sample word is taken only when no frame is being worked on.
// Each finished frame is first windowed into the transform buffer, then each bin
// runs the multiply-accumulate loop over the transform buffer and is then output.
// Reset clears stride to 32, position, ring head and both frame slots.
`timescale 1ns / 1ps
`default_nettype none
module hamming_stft_frames (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               stride_write,
    input  wire logic [12:0]        stride_samples,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] sample,
    input  wire logic               end_of_stream,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [4:0]              bin_index,
    output logic signed [21:0]      real_part,
    output logic signed [21:0]      imag_part,
    output logic                    last_bin
);

    localparam int IW = hsf_pkg::IDX_W;
    localparam int FW = hsf_pkg::FILL_W;

    typedef enum logic [1:0] {S_IDLE, S_FILL, S_DFT, S_OUT} state_t;

    state_t state_reg;
    logic [12:0] stride_reg;
    logic [11:0] pos_reg;
    logic [IW-1:0] head_reg;
    logic [FW-1:0] fill_reg [2];
    logic [1:0]    pend_valid_reg;
    logic [FW-1:0] pend_fill_reg [2];
    logic [IW-1:0] emit_head_reg;
    logic [FW:0]   cnt_reg;
    logic [IW-1:0] k_reg;
    logic [IW-1:0] m_reg;
    logic [4:0]    bin_reg;
    logic signed [21:0] re_out_reg;
    logic signed [21:0] im_out_reg;
    logic          last_reg;

    logic          accept;
    logic [12:0]   st_clamp;
    logic [12:0]   pos_inc;
    logic [FW-1:0] f_new [2];
    logic          start0;
    logic          start1;
    logic [1:0]    emit;
    logic          swap;
    logic [IW-1:0] head_inc;

    hsf_pkg::hsf_tb_wr_t   tb_wr;
    hsf_pkg::hsf_mac_cmd_t cmd;
    logic          win_issue;
    logic          win_zero;
    logic [IW-1:0] win_addr;
    logic          acc_clr;
    logic signed [hsf_pkg::ACC_W-1:0] acc_re;
    logic signed [hsf_pkg::ACC_W-1:0] acc_im;
    logic          mac_done;
    logic signed [hsf_pkg::ACC_W-1:0] re_rnd;
    logic signed [hsf_pkg::ACC_W-1:0] im_rnd;
    logic signed [21:0] re_sat;
    logic signed [21:0] im_sat;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Stride in use, clamped to the legal range.
    always_comb
    begin
        st_clamp = stride_reg;
        if (stride_reg < 13'(hsf_pkg::STRIDE_MIN))
        begin
            st_clamp = 13'(hsf_pkg::STRIDE_MIN);
        end
        else if (stride_reg > 13'(hsf_pkg::STRIDE_MAX))
        begin
            st_clamp = 13'(hsf_pkg::STRIDE_MAX);
        end
    end

    // Frame slot bookkeeping for the accepted sample.
    always_comb
    begin
        start0   = (pos_reg == '0) && (fill_reg[0] == '0);
        start1   = (pos_reg == '0) && (fill_reg[0] != '0) && (fill_reg[1] == '0);
        f_new[0] = start0 ? FW'(1) : ((fill_reg[0] != '0) ? fill_reg[0] + FW'(1) : '0);
        f_new[1] = start1 ? FW'(1) : ((fill_reg[1] != '0) ? fill_reg[1] + FW'(1) : '0);
        emit[0]  = (f_new[0] != '0) &&
                   ((f_new[0] >= FW'(hsf_pkg::WINDOW_LEN)) || end_of_stream);
        emit[1]  = (f_new[1] != '0) &&
                   ((f_new[1] >= FW'(hsf_pkg::WINDOW_LEN)) || end_of_stream);
        swap     = (f_new[1] > f_new[0]);
        pos_inc  = {1'b0, pos_reg} + 13'd1;
        head_inc = head_reg + IW'(1);
    end

    // Window read: the ring slot of frame sample n.
    assign win_issue = (state_reg == S_FILL) && (cnt_reg < (FW+1)'(hsf_pkg::WINDOW_LEN));
    assign win_zero  = ({1'b0, cnt_reg[IW-1:0]} >= pend_fill_reg[0]);
    assign win_addr  = emit_head_reg - pend_fill_reg[0][IW-1:0] + cnt_reg[IW-1:0];

    assign cmd.en   = (state_reg == S_DFT) && (cnt_reg < (FW+1)'(hsf_pkg::WINDOW_LEN));
    assign cmd.addr = cnt_reg[IW-1:0];
    assign cmd.tw   = m_reg;
    assign cmd.last = (cnt_reg == (FW+1)'(hsf_pkg::WINDOW_LEN - 1));

    assign acc_clr = ((state_reg == S_FILL) && (cnt_reg == (FW+1)'(hsf_pkg::WINDOW_LEN + 2)))
                  || ((state_reg == S_OUT) && !out_stall);

    hsf_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .ring_wr      (accept),
        .ring_wr_addr (head_reg),
        .ring_wr_data (sample),
        .issue        (win_issue),
        .issue_zero   (win_zero),
        .ring_rd_addr (win_addr),
        .issue_idx    (cnt_reg[IW-1:0]),
        .tb_wr        (tb_wr)
    );

    hsf_dft u_dft (
        .clk     (clk),
        .rst_n   (rst_n),
        .tb_wr   (tb_wr),
        .cmd     (cmd),
        .acc_clr (acc_clr),
        .acc_re  (acc_re),
        .acc_im  (acc_im),
        .done    (mac_done)
    );

    // Round the accumulated bin once and saturate to 22 bits.
    always_comb
    begin
        re_rnd = (acc_re + hsf_pkg::ACC_W'(16384)) >>> 15;
        im_rnd = (acc_im + hsf_pkg::ACC_W'(16384)) >>> 15;
        if (re_rnd > hsf_pkg::ACC_W'(2097151))
        begin
            re_sat = 22'sd2097151;
        end
        else if (re_rnd < -hsf_pkg::ACC_W'(2097152))
        begin
            re_sat = -22'sd2097152;
        end
        else
        begin
            re_sat = re_rnd[21:0];
        end
        if (im_rnd > hsf_pkg::ACC_W'(2097151))
        begin
            im_sat = 22'sd2097151;
        end
        else if (im_rnd < -hsf_pkg::ACC_W'(2097152))
        begin
            im_sat = -22'sd2097152;
        end
        else
        begin
            im_sat = im_rnd[21:0];
        end
    end

    // Sequencer: take a word, window each finished frame, run each bin.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            stride_reg     <= 13'd32;
            pos_reg        <= '0;
            head_reg       <= '0;
            fill_reg[0]    <= '0;
            fill_reg[1]    <= '0;
            pend_valid_reg <= '0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            m_reg          <= '0;
        end
        else
        begin
            if (stride_write)
            begin
                stride_reg <= stride_samples;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        // An end of stream returns the position state to reset.
                        pos_reg       <= (end_of_stream || (pos_inc >= st_clamp)) ?
                                         '0 : pos_inc[11:0];
                        head_reg      <= end_of_stream ? '0 : head_inc;
                        emit_head_reg <= head_inc;
                        fill_reg[0]   <= (emit[0] || end_of_stream) ? '0 : f_new[0];
                        fill_reg[1]   <= (emit[1] || end_of_stream) ? '0 : f_new[1];
                        // Older frame, the one with the larger fill, goes first.
                        if (emit[0] && emit[1])
                        begin
                            pend_fill_reg[0] <= swap ? f_new[1] : f_new[0];
                            pend_fill_reg[1] <= swap ? f_new[0] : f_new[1];
                            pend_valid_reg   <= 2'b11;
                        end
                        else if (emit[0] || emit[1])
                        begin
                            pend_fill_reg[0] <= emit[0] ? f_new[0] : f_new[1];
                            pend_valid_reg   <= 2'b01;
                        end
                        else
                        begin
                            pend_valid_reg <= 2'b00;
                        end
                        if (emit != 2'b00)
                        begin
                            state_reg <= S_FILL;
                            cnt_reg   <= '0;
                        end
                    end
                end
                S_FILL:
                begin
                    if (cnt_reg == (FW+1)'(hsf_pkg::WINDOW_LEN + 2))
                    begin
                        state_reg <= S_DFT;
                        cnt_reg   <= '0;
                        k_reg     <= '0;
                        m_reg     <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + (FW+1)'(1);
                    end
                end
                S_DFT:
                begin
                    if (cmd.en)
                    begin
                        cnt_reg <= cnt_reg + (FW+1)'(1);
                        m_reg   <= m_reg + k_reg;
                    end
                    if (mac_done)
                    begin
                        state_reg  <= S_OUT;
                        bin_reg    <= 5'(k_reg);
                        re_out_reg <= re_sat;
                        im_out_reg <= im_sat;
                        last_reg   <= (k_reg == IW'(hsf_pkg::NUM_BINS - 1));
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        cnt_reg <= '0;
                        m_reg   <= '0;
                        if (k_reg == IW'(hsf_pkg::NUM_BINS - 1))
                        begin
                            if (pend_valid_reg[1])
                            begin
                                pend_fill_reg[0] <= pend_fill_reg[1];
                                pend_valid_reg   <= 2'b01;
                                state_reg        <= S_FILL;
                            end
                            else
                            begin
                                pend_valid_reg <= 2'b00;
                                state_reg      <= S_IDLE;
                            end
                        end
                        else
                        begin
                            k_reg     <= k_reg + IW'(1);
                            state_reg <= S_DFT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = (state_reg == S_OUT);
    assign bin_index = bin_reg;
    assign real_part = re_out_reg;
    assign imag_part = im_out_reg;
    assign last_bin  = last_reg;

    // Checks on the sequencer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input taken while a bin is pending");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_bin == (bin_index == 5'(hsf_pkg::NUM_BINS - 1))))
        else $error("last bin mark does not match bin number");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg[0] < FW'(hsf_pkg::WINDOW_LEN)) && (fill_reg[1] < FW'(hsf_pkg::WINDOW_LEN)))
        else $error("frame slot kept a full frame");

endmodule
`default_nettype wire

// ===== hw/rtl/hsf_window.sv =====
// Sample ring memory and the window multiplier.
// Produces transform buffer writes; depends on hsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsf_window (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        ring_wr,
    input  wire logic [hsf_pkg::IDX_W-1:0]   ring_wr_addr,
    input  wire logic signed [15:0]          ring_wr_data,
    input  wire logic                        issue,
    input  wire logic                        issue_zero,
    input  wire logic [hsf_pkg::IDX_W-1:0]   ring_rd_addr,
    input  wire logic [hsf_pkg::IDX_W-1:0]   issue_idx,
    output hsf_pkg::hsf_tb_wr_t              tb_wr
);

    logic signed [15:0] ring_mem [hsf_pkg::WINDOW_LEN];
    logic signed [15:0] rd_q_reg;
    logic               v1_reg;
    logic               z1_reg;
    logic [hsf_pkg::IDX_W-1:0] n1_reg;
    logic               v2_reg;
    logic               z2_reg;
    logic [hsf_pkg::IDX_W-1:0] n2_reg;
    logic signed [31:0] prod_reg;
    logic signed [31:0] prod_next;
    logic signed [15:0] win_coef;
    logic signed [31:0] rnd;

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ring_wr)
        begin
            ring_mem[ring_wr_addr] <= ring_wr_data;
        end
        if (issue && !issue_zero)
        begin
            rd_q_reg <= ring_mem[ring_rd_addr];
        end
    end

    assign win_coef  = hsf_pkg::WIN_TAB[n1_reg];
    assign prod_next = rd_q_reg * win_coef;

    // Two pipeline steps: read, then product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        z1_reg   <= issue_zero;
        n1_reg   <= issue_idx;
        z2_reg   <= z1_reg;
        n2_reg   <= n1_reg;
        prod_reg <= prod_next;
    end

    // Round to the nearest, ties upward, by a floor of the offset product.
    assign rnd        = prod_reg + 32'sd16384;
    assign tb_wr.en   = v2_reg;
    assign tb_wr.addr = n2_reg;
    assign tb_wr.data = z2_reg ? 16'sd0 : rnd[30:15];

endmodule
`default_nettype wire

// ===== hw/rtl/hsf_dft.sv =====
// Transform buffer memory and the complex multiply-accumulate unit.
// Depends on hsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsf_dft (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hsf_pkg::hsf_tb_wr_t           tb_wr,
    input  wire hsf_pkg::hsf_mac_cmd_t         cmd,
    input  wire logic                          acc_clr,
    output logic signed [hsf_pkg::ACC_W-1:0]   acc_re,
    output logic signed [hsf_pkg::ACC_W-1:0]   acc_im,
    output logic                               done
);

    logic signed [15:0] tbuf_mem [hsf_pkg::WINDOW_LEN];
    logic signed [15:0] x_q_reg;
    logic               v1_reg;
    logic               last1_reg;
    logic [hsf_pkg::IDX_W-1:0] tw1_reg;
    logic               v2_reg;
    logic               last2_reg;
    logic signed [31:0] pc_reg;
    logic signed [31:0] ps_reg;
    logic signed [15:0] cos_coef;
    logic signed [15:0] sin_coef;
    logic signed [31:0] pc_next;
    logic signed [31:0] ps_next;
    logic signed [hsf_pkg::ACC_W-1:0] re_reg;
    logic signed [hsf_pkg::ACC_W-1:0] im_reg;
    logic               done_reg;

    // Transform buffer: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (tb_wr.en)
        begin
            tbuf_mem[tb_wr.addr] <= tb_wr.data;
        end
        if (cmd.en)
        begin
            x_q_reg <= tbuf_mem[cmd.addr];
        end
    end

    assign cos_coef = hsf_pkg::COS_TAB[tw1_reg];
    assign sin_coef = hsf_pkg::SIN_TAB[tw1_reg];
    assign pc_next  = x_q_reg * cos_coef;
    assign ps_next  = x_q_reg * sin_coef;

    always_ff @(posedge clk)
    begin
        tw1_reg   <= cmd.tw;
        last1_reg <= cmd.last;
        last2_reg <= last1_reg;
        pc_reg    <= pc_next;
        ps_reg    <= ps_next;
    end

    // Accumulate the real part and the negated sine part.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
            re_reg   <= '0;
            im_reg   <= '0;
        end
        else
        begin
            v1_reg   <= cmd.en;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg && last2_reg;
            if (acc_clr)
            begin
                re_reg <= '0;
                im_reg <= '0;
            end
            else if (v2_reg)
            begin
                re_reg <= re_reg + hsf_pkg::ACC_W'(pc_reg);
                im_reg <= im_reg - hsf_pkg::ACC_W'(ps_reg);
            end
        end
    end

    assign acc_re = re_reg;
    assign acc_im = im_reg;
    assign done   = done_reg;

endmodule
`default_nettype wire
